FILE: rtl/ogru_pkg.sv
// Shared types, constants and helpers for the occupancy grid ray update block.
// No dependencies; every other file imports this package.
`default_nettype none

package ogru_pkg;

   localparam int GRID_SIDE_DEFAULT = 256;

   localparam int COORD_IN_W = 12;
   localparam int CELL_W     = 16;
   localparam int QUALITY_W  = 9;
   localparam int TOUCH_W    = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [QUALITY_W-1:0] QUALITY_ONE   = 9'd256;
   localparam logic [QUALITY_W-1:0] QUALITY_RESET = 9'd64;
   localparam logic [CELL_W-1:0]    CELL_FREE     = 16'd65535;
   localparam logic [CELL_W-1:0]    CLEAR_RESET   = 16'd32768;

   typedef logic [1:0] op_type;
   localparam op_type OP_RAY   = 2'd0;
   localparam op_type OP_READ  = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_UPDATE_QUALITY = 1'd0;
   localparam csr_idx_type CSR_CLEAR_VALUE    = 1'd1;

   typedef logic signed [COORD_IN_W-1:0] coord_type;

   typedef struct packed {
      logic load;
      logic advance;
   } walk_cmd_type;

   typedef struct packed {
      logic in_grid;
      logic at_end;
   } walk_status_type;

   function automatic logic coord_in_range(input coord_type c,
                                           input logic [COORD_IN_W-1:0] side);
      coord_in_range = !c[COORD_IN_W-1] && ($unsigned(c) < side);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ogru_if.sv
// Request and response channel interfaces of the occupancy grid ray update block.
// Depends on ogru_pkg for field types.
`default_nettype none

interface ogru_req_if import ogru_pkg::*; ();
   logic      valid;
   logic      ready;
   op_type    op;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ogru_rsp_if import ogru_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CELL_W-1:0]  read_value;
   logic [TOUCH_W-1:0] cells_touched;
   logic               end_in_grid;

   modport source (output valid, read_value, cells_touched, end_in_grid, input ready);
   modport sink   (input valid, read_value, cells_touched, end_in_grid, output ready);
endinterface

`default_nettype wire

FILE: rtl/ogru_grid_mem.sv
// Single-port-write, single-port-read cell memory with registered read data.
// Depends on ogru_pkg for the cell width.
`default_nettype none

module ogru_grid_mem import ogru_pkg::*; #(
   parameter int DEPTH = GRID_SIDE_DEFAULT * GRID_SIDE_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [CELL_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ogru_blend.sv
// Shared cell update unit: one multiplier that moves a cell toward free or occupied.
// Depends on ogru_pkg for widths and the quality and free constants.
`default_nettype none

module ogru_blend import ogru_pkg::*; (
   input  wire logic [CELL_W-1:0]    cell_cur,
   input  wire logic [QUALITY_W-1:0] quality,
   input  wire logic                 to_occupied,
   output logic      [CELL_W-1:0]    cell_new
);

   localparam int PROD_W = CELL_W + QUALITY_W;

   logic [QUALITY_W-1:0] q_sat;
   logic [CELL_W-1:0]    mul_a;
   logic [QUALITY_W-1:0] mul_b;
   logic [PROD_W-1:0]    prod;
   logic [CELL_W-1:0]    scaled;

   always_comb begin
      q_sat  = (quality > QUALITY_ONE) ? QUALITY_ONE : quality;
      mul_a  = to_occupied ? cell_cur : (CELL_FREE - cell_cur);
      mul_b  = to_occupied ? (QUALITY_ONE - q_sat) : q_sat;
      prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
      scaled = prod[CELL_W+7:8];
      cell_new = to_occupied ? scaled : (cell_cur + scaled);
   end

endmodule

`default_nettype wire

FILE: rtl/ogru_line_step.sv
// Bresenham line stepper: holds the current cell and error term and forms its address.
// Depends on ogru_pkg for coordinate types and the command and status structs.
`default_nettype none

module ogru_line_step import ogru_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEFAULT,
   parameter int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE)
) (
   input  wire logic              clock,
   input  wire walk_cmd_type      cmd,
   input  wire coord_type         x0,
   input  wire coord_type         y0,
   input  wire coord_type         x1,
   input  wire coord_type         y1,
   output walk_status_type        status,
   output logic      [ADDR_W-1:0] addr
);

   localparam int COORD_W = $clog2(GRID_SIDE);
   localparam int DIFF_W  = COORD_IN_W + 2;
   localparam int ERR_W   = COORD_IN_W + 3;
   localparam int E2_W    = ERR_W + 1;

   coord_type                x_ff, x_in, y_ff, y_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic                     sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;

   logic signed [DIFF_W-1:0] diff_x, diff_y;
   logic signed [E2_W-1:0]   e2;
   logic                     step_x, step_y;
   logic signed [ERR_W-1:0]  add_dx, add_dy;
   logic [COORD_W-1:0]       col, row;

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      err_in    = err_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;

      diff_x = DIFF_W'(x1) - DIFF_W'(x0);
      diff_y = DIFF_W'(y1) - DIFF_W'(y0);

      e2     = E2_W'(err_ff) <<< 1;
      step_x = e2 >= E2_W'(dy_ff);
      step_y = e2 <= E2_W'(dx_ff);
      add_dx = step_y ? ERR_W'(dx_ff) : '0;
      add_dy = step_x ? ERR_W'(dy_ff) : '0;

      if (cmd.load) begin
         x_in      = x0;
         y_in      = y0;
         x1_in     = x1;
         y1_in     = y1;
         dx_in     = diff_x[DIFF_W-1] ? -diff_x : diff_x;
         dy_in     = diff_y[DIFF_W-1] ? diff_y : -diff_y;
         err_in    = ERR_W'(dx_in) + ERR_W'(dy_in);
         sx_neg_in = !(x0 < x1);
         sy_neg_in = !(y0 < y1);
      end else if (cmd.advance) begin
         err_in = err_ff + add_dx + add_dy;
         if (step_x) begin
            x_in = sx_neg_ff ? (x_ff - coord_type'(1)) : (x_ff + coord_type'(1));
         end
         if (step_y) begin
            y_in = sy_neg_ff ? (y_ff - coord_type'(1)) : (y_ff + coord_type'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      err_ff    <= err_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
   end

   always_comb begin
      col            = x_ff[COORD_W-1:0];
      row            = y_ff[COORD_W-1:0];
      status.in_grid = coord_in_range(x_ff, COORD_IN_W'(GRID_SIDE))
                       && coord_in_range(y_ff, COORD_IN_W'(GRID_SIDE));
      status.at_end  = (x_ff == x1_ff) && (y_ff == y1_ff);
      addr           = ADDR_W'(row) * ADDR_W'(GRID_SIDE) + ADDR_W'(col);
   end

endmodule

`default_nettype wire

FILE: rtl/occupancy_grid_ray_update.sv
// Occupancy grid ray update, top level: sequencer, configuration registers and result register.
// Depends on ogru_pkg, ogru_if, ogru_grid_mem, ogru_blend and ogru_line_step.
// A ray walks every cell from start to end, reading and writing back each cell inside the grid.
// A read fetches the end cell, an unused op goes straight to the result, and a clear sweeps every cell.
// The shared blend unit and the single memory read-modify-write per cell set the ray rate.
// After reset the grid is swept to 32768 before a transaction is taken.
`default_nettype none

module occupancy_grid_ray_update import ogru_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ogru_req_if.sink                   req_if,
   ogru_rsp_if.source                 rsp_if,
   input  wire logic                  csr_wr_en,
   input  wire csr_idx_type           csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(DEPTH - 1);

   typedef enum logic [6:0] {
      ST_INIT       = 7'b0000001,
      ST_IDLE       = 7'b0000010,
      ST_RAY_VISIT  = 7'b0000100,
      ST_RAY_UPDATE = 7'b0001000,
      ST_READ       = 7'b0010000,
      ST_CLEAR      = 7'b0100000,
      ST_DONE       = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [QUALITY_W-1:0] quality_ff, quality_in;
   logic [CELL_W-1:0]    clear_value_ff, clear_value_in;
   logic [CELL_W-1:0]    fill_ff, fill_in;
   logic [ADDR_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   op_type               op_ff, op_in;
   logic                 end_in_ff, end_in_in;
   logic [TOUCH_W-1:0]   touched_ff, touched_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_read_ff, rsp_read_in;
   logic [TOUCH_W-1:0]   rsp_touched_ff, rsp_touched_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic                 accept;
   walk_cmd_type         walk_cmd;
   walk_status_type      walk;
   logic [ADDR_W-1:0]    walk_addr;
   coord_type            load_x0, load_y0;
   logic                 mem_wr_en, mem_rd_en, sweeping;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [CELL_W-1:0]    mem_wr_data, mem_rd_data, blend_out;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign load_x0      = (req_if.op == OP_READ) ? req_if.end_x : req_if.start_x;
   assign load_y0      = (req_if.op == OP_READ) ? req_if.end_y : req_if.start_y;
   assign sweeping     = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);

   ogru_line_step #(
      .GRID_SIDE (GRID_SIDE),
      .ADDR_W    (ADDR_W)
   ) u_line_step (
      .clock  (clock),
      .cmd    (walk_cmd),
      .x0     (load_x0),
      .y0     (load_y0),
      .x1     (req_if.end_x),
      .y1     (req_if.end_y),
      .status (walk),
      .addr   (walk_addr)
   );

   ogru_blend u_blend (
      .cell_cur    (mem_rd_data),
      .quality     (quality_ff),
      .to_occupied (walk.at_end),
      .cell_new    (blend_out)
   );

   ogru_grid_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (walk_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      mem_wr_en   = sweeping || (state_ff == ST_RAY_UPDATE);
      mem_wr_addr = sweeping ? sweep_cnt_ff : walk_addr;
      mem_wr_data = sweeping ? fill_ff : blend_out;
      mem_rd_en   = walk.in_grid && ((state_ff == ST_RAY_VISIT) || (state_ff == ST_READ));
   end

   always_comb begin
      quality_in     = quality_ff;
      clear_value_in = clear_value_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_UPDATE_QUALITY: begin
               quality_in = csr_wdata[QUALITY_W-1:0];
            end
            CSR_CLEAR_VALUE: begin
               clear_value_in = csr_wdata[CELL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      op_in          = op_ff;
      end_in_in      = end_in_ff;
      touched_in     = touched_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_read_in    = rsp_read_ff;
      rsp_touched_in = rsp_touched_ff;
      rsp_end_in     = rsp_end_ff;
      walk_cmd       = '0;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == SWEEP_LAST) begin
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               walk_cmd.load = 1'b1;
               op_in         = req_if.op;
               end_in_in     = coord_in_range(req_if.end_x, COORD_IN_W'(GRID_SIDE))
                               && coord_in_range(req_if.end_y, COORD_IN_W'(GRID_SIDE));
               touched_in    = '0;
               case (req_if.op)
                  OP_RAY: begin
                     state_in = ST_RAY_VISIT;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_CLEAR: begin
                     fill_in      = clear_value_ff;
                     sweep_cnt_in = '0;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RAY_VISIT: begin
            if (walk.in_grid) begin
               state_in = ST_RAY_UPDATE;
            end else if (walk.at_end) begin
               state_in = ST_DONE;
            end else begin
               walk_cmd.advance = 1'b1;
            end
         end
         ST_RAY_UPDATE: begin
            touched_in = touched_ff + 1'b1;
            if (walk.at_end) begin
               state_in = ST_DONE;
            end else begin
               walk_cmd.advance = 1'b1;
               state_in         = ST_RAY_VISIT;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_read_in    = ((op_ff == OP_READ) && end_in_ff) ? mem_rd_data : '0;
               rsp_touched_in = touched_ff;
               rsp_end_in     = end_in_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         quality_ff     <= QUALITY_RESET;
         clear_value_ff <= CLEAR_RESET;
         fill_ff        <= CLEAR_RESET;
         sweep_cnt_ff   <= '0;
         touched_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         quality_ff     <= quality_in;
         clear_value_ff <= clear_value_in;
         fill_ff        <= fill_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         touched_ff     <= touched_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff          <= op_in;
      end_in_ff      <= end_in_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_touched_ff <= rsp_touched_in;
      rsp_end_ff     <= rsp_end_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_value    = rsp_read_ff;
   assign rsp_if.cells_touched = rsp_touched_ff;
   assign rsp_if.end_in_grid   = rsp_end_ff;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("Grid memory read and write in the same cycle.");

   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RAY_UPDATE) |-> ($past(state_ff) == ST_RAY_VISIT && $past(mem_rd_en)))
      else $error("Cell update without a preceding read.");

   a_ray_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.op == OP_RAY) |=> (state_ff == ST_RAY_VISIT && touched_ff == '0))
      else $error("Ray transaction did not start a fresh walk.");

   a_clear_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && $past(state_ff) == ST_IDLE) |-> (sweep_cnt_ff == '0))
      else $error("Clear sweep did not start at the first cell.");

   a_touched_bound: assert property (@(posedge clock) disable iff (reset)
      touched_ff <= TOUCH_W'(4096))
      else $error("Touched cell count out of range.");

endmodule

`default_nettype wire
